// ===== sv/smae_pkg.sv =====
// smae_pkg: shared types and codes for the small matrix arithmetic engine
// transaction structs, command/mode/register codes and the ctrl/datapath interface
// no dependencies
`timescale 1ns / 1ps

package smae_pkg;

  // fixed field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned DIM_W  = 4;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 4;

  // input commands
  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;

  // mode register codes
  localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TRA = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TRB = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd4;

  // datapath operation of a run
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_TRA,
    OP_TRB
  } op_e;

  // input transaction
  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic                     dim_error;
    logic                     last;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_en;
    logic             first;
    logic             last_term;
    op_e              op;
    logic [IDX_W-1:0] a_row;
    logic [IDX_W-1:0] a_col;
    logic [IDX_W-1:0] b_row;
    logic [IDX_W-1:0] b_col;
    logic             load_out;
    logic             out_err;
    logic             out_last;
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
  } smae_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } smae_sts_t;

endpackage

// ===== sv/smae_datapath.sv =====
// smae_datapath: element stores, read/multiply/accumulate pipeline and output register
// depends on smae_pkg; driven by smae_ctrl through smae_cmd_t
`timescale 1ns / 1ps

module smae_datapath import smae_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  smae_cmd_t cmd_i,
  output smae_sts_t sts_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  // row-major element address
  function automatic logic [AW-1:0] addr_f(input logic [IDX_W-1:0] r,
                                           input logic [IDX_W-1:0] c);
    addr_f = AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  logic [DATA_W-1:0] mem_a [Depth];
  logic [DATA_W-1:0] mem_b [Depth];

  logic [DATA_W-1:0] a_rd_q, b_rd_q;
  logic              v1_q, first1_q, last1_q;
  op_e               op1_q;
  logic [DATA_W-1:0] term_d, term_q;
  logic              v2_q, first2_q, last2_q;
  logic [DATA_W-1:0] acc_q;
  logic              acc_done_q;
  out_item_t         out_q;
  logic              out_valid_q;
  logic [AW-1:0]     wr_addr;

  assign wr_addr = addr_f(in_data_i.row, in_data_i.col);

  // store writes from load transactions
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      mem_a[wr_addr] <= in_data_i.value;
    end
    if (cmd_i.wr_b) begin
      mem_b[wr_addr] <= in_data_i.value;
    end
  end

  // registered store reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      a_rd_q <= mem_a[addr_f(cmd_i.a_row, cmd_i.a_col)];
      b_rd_q <= mem_b[addr_f(cmd_i.b_row, cmd_i.b_col)];
    end
  end

  // term for the selected operation
  always_comb begin
    unique case (op1_q)
      OP_ADD:  term_d = a_rd_q + b_rd_q;
      OP_SUB:  term_d = a_rd_q - b_rd_q;
      OP_MUL:  term_d = DATA_W'(a_rd_q * b_rd_q);
      OP_TRA:  term_d = a_rd_q;
      OP_TRB:  term_d = b_rd_q;
      default: term_d = a_rd_q;
    endcase
  end

  // pipeline valids and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      acc_done_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
      if (cmd_i.load_out) begin
        acc_done_q <= 1'b0;
      end else if (v2_q && last2_q) begin
        acc_done_q <= 1'b1;
      end
    end
  end

  // pipeline payload and accumulator
  always_ff @(posedge clk_i) begin
    first1_q <= cmd_i.first;
    last1_q  <= cmd_i.last_term;
    op1_q    <= cmd_i.op;
    term_q   <= term_d;
    first2_q <= first1_q;
    last2_q  <= last1_q;
    if (v2_q) begin
      acc_q <= first2_q ? term_q : acc_q + term_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.result    <= cmd_i.out_err ? '0 : acc_q;
      out_q.out_row   <= cmd_i.out_row;
      out_q.out_col   <= cmd_i.out_col;
      out_q.dim_error <= cmd_i.out_err;
      out_q.last      <= cmd_i.out_last;
    end
  end

  assign sts_o.acc_done = acc_done_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  // a finished element is never overwritten before it is moved out
  a_no_acc_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && last2_q) |-> !acc_done_q)
    else $error("accumulator finished while previous element still pending");

  // a good element is moved out only once it is complete
  a_load_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && !cmd_i.out_err) |-> acc_done_q)
    else $error("output loaded before accumulation finished");

  // pending output register is never clobbered
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register loaded while holding an untaken result");

endmodule

// ===== sv/smae_ctrl.sv =====
// smae_ctrl: configuration registers and run sequencer of the matrix engine
// depends on smae_pkg; commands smae_datapath through smae_cmd_t
`timescale 1ns / 1ps

module smae_ctrl import smae_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  in_item_t              in_data_i,
  output logic                  in_ready_o,
  input  smae_sts_t             sts_i,
  output smae_cmd_t             cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_ERR
  } state_e;

  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    dim_ok = (d != '0) && (int'(d) <= MAX_DIM);
  endfunction

  state_e            state_q;
  logic [DIM_W-1:0]  rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic [MODE_W-1:0] mode_q;
  logic [DIM_W-1:0]  nr_q, nc_q, nk_q;
  logic [DIM_W-1:0]  nr_d, nc_d, nk_d;
  logic [IDX_W-1:0]  i_q, j_q, k_q;
  op_e               op_q, op_d;
  logic              ok;
  logic              accept, run_acc, in_range;
  logic              i_last, j_last, k_last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign run_acc    = accept && (in_data_i.command == CMD_RUN);
  assign in_range   = (int'(in_data_i.row) < MAX_DIM) && (int'(in_data_i.col) < MAX_DIM);

  assign i_last = ({1'b0, i_q} + 1'b1) == nr_q;
  assign j_last = ({1'b0, j_q} + 1'b1) == nc_q;
  assign k_last = ({1'b0, k_q} + 1'b1) == nk_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= DIM_W'(1);
      cols_a_q <= DIM_W'(1);
      rows_b_q <= DIM_W'(1);
      cols_b_q <= DIM_W'(1);
      mode_q   <= MODE_ADD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS_A: rows_a_q <= cfg_wdata_i;
        CFG_COLS_A: cols_a_q <= cfg_wdata_i;
        CFG_ROWS_B: rows_b_q <= cfg_wdata_i;
        CFG_COLS_B: cols_b_q <= cfg_wdata_i;
        CFG_MODE:   mode_q   <= cfg_wdata_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // dimension check and loop bounds of a run
  always_comb begin
    ok   = 1'b0;
    op_d = OP_ADD;
    nr_d = rows_a_q;
    nc_d = cols_a_q;
    nk_d = DIM_W'(1);
    unique case (mode_q)
      MODE_ADD, MODE_SUB: begin
        ok   = dim_ok(rows_a_q) && dim_ok(cols_a_q) &&
               (rows_a_q == rows_b_q) && (cols_a_q == cols_b_q);
        op_d = (mode_q == MODE_ADD) ? OP_ADD : OP_SUB;
      end
      MODE_MUL: begin
        ok   = dim_ok(rows_a_q) && dim_ok(cols_a_q) && dim_ok(cols_b_q) &&
               (cols_a_q == rows_b_q);
        op_d = OP_MUL;
        nc_d = cols_b_q;
        nk_d = cols_a_q;
      end
      MODE_TRA: begin
        ok   = dim_ok(rows_a_q) && dim_ok(cols_a_q);
        op_d = OP_TRA;
        nr_d = cols_a_q;
        nc_d = rows_a_q;
      end
      MODE_TRB: begin
        ok   = dim_ok(rows_b_q) && dim_ok(cols_b_q);
        op_d = OP_TRB;
        nr_d = cols_b_q;
        nc_d = rows_b_q;
      end
      default: ok = 1'b0;
    endcase
  end

  // command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = op_q;
    cmd_o.wr_a      = accept && in_range && (in_data_i.command == CMD_LOAD_A);
    cmd_o.wr_b      = accept && in_range && (in_data_i.command == CMD_LOAD_B);
    cmd_o.first     = (k_q == '0);
    cmd_o.last_term = k_last;
    cmd_o.out_row   = i_q;
    cmd_o.out_col   = j_q;
    cmd_o.out_last  = i_last && j_last;
    unique case (op_q)
      OP_ADD, OP_SUB: begin
        cmd_o.a_row = i_q;
        cmd_o.a_col = j_q;
        cmd_o.b_row = i_q;
        cmd_o.b_col = j_q;
      end
      OP_MUL: begin
        cmd_o.a_row = i_q;
        cmd_o.a_col = k_q;
        cmd_o.b_row = k_q;
        cmd_o.b_col = j_q;
      end
      default: begin
        cmd_o.a_row = j_q;
        cmd_o.a_col = i_q;
        cmd_o.b_row = j_q;
        cmd_o.b_col = i_q;
      end
    endcase
    unique case (state_q)
      ST_ISSUE: cmd_o.rd_en = 1'b1;
      ST_WAIT:  cmd_o.load_out = sts_i.acc_done && sts_i.out_free;
      ST_ERR: begin
        cmd_o.load_out = sts_i.out_free;
        cmd_o.out_err  = 1'b1;
        cmd_o.out_last = 1'b1;
        cmd_o.out_row  = '0;
        cmd_o.out_col  = '0;
      end
      default: ;
    endcase
  end

  // run sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_ADD;
      nr_q    <= DIM_W'(1);
      nc_q    <= DIM_W'(1);
      nk_q    <= DIM_W'(1);
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (run_acc) begin
            op_q    <= op_d;
            nr_q    <= nr_d;
            nc_q    <= nc_d;
            nk_q    <= nk_d;
            i_q     <= '0;
            j_q     <= '0;
            k_q     <= '0;
            state_q <= ok ? ST_ISSUE : ST_ERR;
          end
        end
        ST_ISSUE: begin
          if (k_last) begin
            state_q <= ST_WAIT;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_WAIT: begin
          if (sts_i.acc_done && sts_i.out_free) begin
            k_q <= '0;
            if (j_last) begin
              j_q <= '0;
              if (i_last) begin
                state_q <= ST_IDLE;
              end else begin
                i_q     <= i_q + 1'b1;
                state_q <= ST_ISSUE;
              end
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_ERR: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // reads only while walking terms
  a_rd_in_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> (state_q == ST_ISSUE))
    else $error("store read issued outside term walk");

  // the final result of a run returns the sequencer to idle
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_out && cmd_o.out_last) |=> (state_q == ST_IDLE))
    else $error("run did not end after its last result");

  // a load never happens during a run
  a_no_write_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_a || cmd_o.wr_b) |-> (state_q == ST_IDLE && !cmd_o.rd_en))
    else $error("store written while a run is active");

endmodule

// ===== sv/small_matrix_arith_engine.sv =====
// small_matrix_arith_engine: top level of the integer matrix add/sub/multiply/transpose engine
// depends on smae_pkg, smae_ctrl and smae_datapath
`timescale 1ns / 1ps

// Usage
//   in channel (in_valid_i/in_ready_o/in_data_i): a load transaction writes one element
//   of A or B at row/col and produces nothing; a run transaction walks the result
//   matrix in row-major order and emits one out transaction per element, last marked.
//   out channel (out_valid_o/out_ready_i/out_data_o): result transactions.
//   config port (cfg_we_i/cfg_idx_i/cfg_wdata_i): rows_a, cols_a, rows_b, cols_b, mode;
//   to be written only while the engine is idle; the block itself does not enforce this.
// Timing
//   a load is written to its store when accepted. a run is accepted only when idle and holds the input
//   until its last element is in the output register. each element issues nk store
//   reads in turn (nk = cols_a for multiply, 1 otherwise), set by the single read
//   port of each element store, then passes the read, term and accumulate stages;
//   the next element starts only once its result is in the output register.
//   a dimension or mode error gives one result with dim_error and last set.
// Reset and stalls
//   reset sets the dimension registers to 1 and mode to add; store contents are
//   undefined until loaded. a stalled receiver holds the sequencer before each
//   element; loads and new runs are taken once the last result is registered.

module small_matrix_arith_engine import smae_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o
);

  smae_cmd_t cmd;
  smae_sts_t sts;

  // sequencer and configuration
  smae_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // stores and arithmetic
  smae_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
